// ===== hw/rtl/latency_target_chunk_size_defines.svh =====
// Assertion macros shared by the checker of the chunk sizing block.
// No dependencies; included by the checker file.
`ifndef LATENCY_TARGET_CHUNK_SIZE_DEFINES_SVH
`define LATENCY_TARGET_CHUNK_SIZE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define LTCS_ASSERT_RST(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ltcs check failed");

// Implication checked on every clock edge, reset included.
`define LTCS_ASSERT_ALL(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ltcs check failed");

`endif

// ===== hw/rtl/ltcs_pkg.sv =====
// Shared types and register codes of the chunk sizing block.
// No dependencies.
package ltcs_pkg;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_BASE  = 3'd0,
        REG_MIN   = 3'd1,
        REG_GAIN  = 3'd2,
        REG_ALIGN = 3'd3,
        REG_READY = 3'd4,
        REG_QUAD  = 3'd5,
        REG_LIN   = 3'd6,
        REG_TGT   = 3'd7
    } t_reg_idx;

    localparam int unsigned CHUNK_BITS = 16;
    localparam logic [16:0] GAIN_ONE = 17'd65536;

    // Per-item data that rides along the pipeline.
    typedef struct packed {
        logic                  vld;
        logic [CHUNK_BITS-1:0] cap;
        logic [CHUNK_BITS-1:0] rem16;
        logic                  rem_big;
        logic                  dz;
        logic [CHUNK_BITS-1:0] bnd;
        logic                  eq;
    } t_side;

endpackage

// ===== hw/rtl/ltcs_root_cell.sv =====
// One cell of the root search chain: decides one bit of the root.
// Depends on ltcs_pkg.
module ltcs_root_cell #(
    parameter int unsigned WIDE = 124,
    parameter int unsigned XB   = 32,
    parameter int unsigned BIT  = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ltcs_pkg::t_side    i_side,
    input  logic [XB-1:0]      i_x,
    input  logic [WIDE-1:0]    i_f,
    input  logic [WIDE-1:0]    i_g,
    input  logic [47:0]        i_q,
    input  logic [WIDE-1:0]    i_rhs,
    output ltcs_pkg::t_side    o_side,
    output logic [XB-1:0]      o_x,
    output logic [WIDE-1:0]    o_f,
    output logic [WIDE-1:0]    o_g
);
    import ltcs_pkg::*;

    logic [WIDE-1:0] w_trial;
    logic            w_ok;
    t_side           r_side;
    logic [XB-1:0]   r_x;
    logic [WIDE-1:0] r_f;
    logic [WIDE-1:0] r_g;

    // f(x + 2^b) = f(x) + 2^b * g(x) + q * 2^(2b), with g(x) = 2qx + s.
    assign w_trial = i_f + (i_g << BIT) + (WIDE'(i_q) << (2 * BIT));
    assign w_ok    = (w_trial <= i_rhs);

    // Reset clears the valid bit; the payload registers are not reset.
    always_ff @(posedge i_clk) begin
        r_x <= i_x | (XB'(w_ok) << BIT);
        r_f <= w_ok ? w_trial : i_f;
        r_g <= w_ok ? (i_g + (WIDE'(i_q) << (BIT + 1))) : i_g;
        if (!i_rst_n) begin
            r_side.vld <= 1'b0;
        end else begin
            r_side <= i_side;
        end
    end

    assign o_side = r_side;
    assign o_x    = r_x;
    assign o_f    = r_f;
    assign o_g    = r_g;
endmodule

// ===== hw/rtl/ltcs_mod_cell.sv =====
// One cell of the remainder chain: one restoring step of bounded % align.
// Depends on ltcs_pkg.
module ltcs_mod_cell #(
    parameter int unsigned BIT = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ltcs_pkg::t_side i_side,
    input  logic [16:0]     i_r,
    input  logic [15:0]     i_align,
    output ltcs_pkg::t_side o_side,
    output logic [16:0]     o_r
);
    import ltcs_pkg::*;

    logic [16:0] w_t;
    t_side       r_side;
    logic [16:0] r_r;

    // Shift in the next bit of the dividend and subtract when it fits.
    assign w_t = {i_r[15:0], i_side.bnd[BIT]};

    always_ff @(posedge i_clk) begin
        r_r <= (w_t >= {1'b0, i_align}) ? (w_t - {1'b0, i_align}) : w_t;
        if (!i_rst_n) begin
            r_side.vld <= 1'b0;
        end else begin
            r_side <= i_side;
        end
    end

    assign o_side = r_side;
    assign o_r    = r_r;
endmodule

// ===== hw/rtl/latency_target_chunk_size.sv =====
// Top level of the latency-target chunk sizing block.
// Depends on ltcs_pkg, ltcs_root_cell and ltcs_mod_cell.
//
// Usage: raise start with history, remaining and budget on the input ports;
// the item is taken at that edge whenever busy is low. busy is always low,
// so one item may enter in every cycle. Each item yields one chunk size on
// o_chunk_size, marked by o_valid for exactly one cycle.
// The pipeline holds three input stages, one cell per root bit
// (16 + FRAC_BITS cells), three smoothing and clamping stages, sixteen
// remainder cells and the output register. Throughput is one item per
// cycle, set by the chains of cells, which each take a new item on every
// clock. The receiver cannot stall; results are shown once and must be
// taken. Synchronous reset empties the pipeline and loads the register
// defaults. The user must write registers over the APB port only while no
// item is in flight; the block itself does not enforce this.
module latency_target_chunk_size #(
    parameter int unsigned LEN_BITS  = 24,
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [LEN_BITS-1:0] i_history_len,
    input  logic [LEN_BITS-1:0] i_remaining_len,
    input  logic [LEN_BITS-1:0] i_token_budget,
    output logic                o_valid,
    output logic [15:0]         o_chunk_size,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);
    import ltcs_pkg::*;

    localparam int unsigned XB   = 16 + FRAC_BITS;
    localparam int unsigned WIDE = 48 + LEN_BITS + 2 * FRAC_BITS + 20;
    localparam int unsigned PB   = 24 + LEN_BITS;
    localparam logic [17+XB:0] RND = {{18{1'b0}}, {XB{1'b1}}};

    // Configuration registers.
    logic [15:0] r_base, r_min, r_align;
    logic [16:0] r_gain;
    logic        r_ready;
    logic [47:0] r_quad;
    logic [39:0] r_lin;
    logic [31:0] r_tgt;
    t_reg_idx    w_idx;

    assign w_idx  = t_reg_idx'(paddr[5:3]);
    assign pready = 1'b1;
    assign busy   = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= 16'd512;
            r_min   <= 16'd64;
            r_gain  <= GAIN_ONE;
            r_align <= 16'd16;
            r_ready <= 1'b0;
            r_quad  <= '0;
            r_lin   <= '0;
            r_tgt   <= '0;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_BASE:  r_base  <= pwdata[15:0];
                REG_MIN:   r_min   <= pwdata[15:0];
                REG_GAIN:  r_gain  <= pwdata[16:0];
                REG_ALIGN: r_align <= pwdata[15:0];
                REG_READY: r_ready <= pwdata[0];
                REG_QUAD:  r_quad  <= pwdata[47:0];
                REG_LIN:   r_lin   <= pwdata[39:0];
                REG_TGT:   r_tgt   <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (w_idx)
            REG_BASE:  prdata = {48'd0, r_base};
            REG_MIN:   prdata = {48'd0, r_min};
            REG_GAIN:  prdata = {47'd0, r_gain};
            REG_ALIGN: prdata = {48'd0, r_align};
            REG_READY: prdata = {63'd0, r_ready};
            REG_QUAD:  prdata = {16'd0, r_quad};
            REG_LIN:   prdata = {24'd0, r_lin};
            REG_TGT:   prdata = {32'd0, r_tgt};
            default:   prdata = '0;
        endcase
    end

    // Stage A: cap, special-case flags and the history register.
    logic [LEN_BITS-1:0] w_cap_rb, w_cap;
    t_side               n_a, r_a;
    logic [LEN_BITS-1:0] r_a_h;

    always_comb begin
        w_cap_rb = (i_token_budget < i_remaining_len) ? i_token_budget : i_remaining_len;
        w_cap    = (LEN_BITS'(r_base) < w_cap_rb) ? LEN_BITS'(r_base) : w_cap_rb;
        n_a.vld     = start;
        n_a.cap     = w_cap[15:0];
        n_a.rem16   = i_remaining_len[15:0];
        n_a.rem_big = ((i_remaining_len >> 16) != '0);
        n_a.dz      = (r_lin == '0) && ((r_quad == '0) || (i_history_len == '0))
                      && ((r_quad == '0) || (r_tgt == '0));
        n_a.bnd     = '0;
        n_a.eq      = 1'b0;
    end

    // Stage B: q * h as two partial products.
    t_side         r_b;
    logic [PB-1:0] r_b_lo, r_b_hi;

    // Stage C: slope term and start values of the root search.
    t_side           r_c;
    logic [WIDE-1:0] r_c_g;
    logic [WIDE-1:0] w_rhs;

    assign w_rhs = WIDE'(r_tgt) << (32 + 2 * FRAC_BITS);

    always_ff @(posedge i_clk) begin
        r_a_h  <= i_history_len;
        r_b_lo <= PB'(r_quad[23:0]) * PB'(r_a_h);
        r_b_hi <= PB'(r_quad[47:24]) * PB'(r_a_h);
        r_c_g  <= (((WIDE'(r_b_hi) << 24) + WIDE'(r_b_lo)) << (FRAC_BITS + 1))
                  + (WIDE'(r_lin) << (16 + FRAC_BITS));
        if (!i_rst_n) begin
            r_a.vld <= 1'b0;
            r_b.vld <= 1'b0;
            r_c.vld <= 1'b0;
        end else begin
            r_a <= n_a;
            r_b <= r_a;
            r_c <= r_b;
        end
    end

    // Root search: one cell per bit, most significant bit first.
    t_side           w_rs [XB+1];
    logic [XB-1:0]   w_rx [XB+1];
    logic [WIDE-1:0] w_rf [XB+1];
    logic [WIDE-1:0] w_rg [XB+1];

    assign w_rs[0] = r_c;
    assign w_rx[0] = '0;
    assign w_rf[0] = '0;
    assign w_rg[0] = r_c_g;

    for (genvar k = 0; k < XB; k++) begin : g_root
        ltcs_root_cell #(
            .WIDE (WIDE),
            .XB   (XB),
            .BIT  (XB - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_side  (w_rs[k]),
            .i_x     (w_rx[k]),
            .i_f     (w_rf[k]),
            .i_g     (w_rg[k]),
            .i_q     (r_quad),
            .i_rhs   (w_rhs),
            .o_side  (w_rs[k+1]),
            .o_x     (w_rx[k+1]),
            .o_f     (w_rf[k+1]),
            .o_g     (w_rg[k+1])
        );
    end

    // Stage P1: distance of the root below the base chunk.
    logic [XB-1:0] w_bfix;
    logic [16:0]   w_geff;
    t_side         r_p1, r_p2, r_p3, n_p3;
    logic          r_p1_sat, r_p2_sat;
    logic [XB-1:0] r_p1_d;
    logic [16+XB:0] r_p2_gd;

    assign w_bfix = {r_base, {FRAC_BITS{1'b0}}};
    assign w_geff = (r_gain > GAIN_ONE) ? GAIN_ONE : r_gain;

    // Stage P3: smoothing, clamps and the cap.
    logic [17+XB:0] w_ceil;
    logic [16:0]    w_des0;
    logic [15:0]    w_des, w_align, w_bnd;

    always_comb begin
        w_ceil  = ({1'b0, r_p2_gd} + RND) >> XB;
        w_des0  = r_p2_sat ? {1'b0, r_base} : ({1'b0, r_base} - w_ceil[16:0]);
        w_des   = w_des0[15:0];
        w_align = (r_align == '0) ? 16'd1 : r_align;
        if (w_des < r_min) w_des = r_min;
        if (w_des > r_base) w_des = r_base;
        if (w_des < w_align) w_des = w_align;
        w_bnd   = (w_des < r_p2.cap) ? w_des : r_p2.cap;
        // Until the model is ready the cap passes straight through.
        n_p3     = r_p2;
        n_p3.bnd = r_ready ? w_bnd : r_p2.cap;
        n_p3.eq  = r_ready ? ((w_bnd == r_p2.rem16) && !r_p2.rem_big) : 1'b1;
    end

    always_ff @(posedge i_clk) begin
        r_p1_sat <= w_rs[XB].dz || (w_rx[XB] >= w_bfix);
        r_p1_d   <= w_bfix - w_rx[XB];
        r_p2_sat <= r_p1_sat;
        r_p2_gd  <= (17 + XB)'(w_geff) * (17 + XB)'(r_p1_d);
        if (!i_rst_n) begin
            r_p1.vld <= 1'b0;
            r_p2.vld <= 1'b0;
            r_p3.vld <= 1'b0;
        end else begin
            r_p1 <= w_rs[XB];
            r_p2 <= r_p1;
            r_p3 <= n_p3;
        end
    end

    // Remainder chain for the floor to the alignment step.
    t_side       w_ms [17];
    logic [16:0] w_mr [17];

    assign w_ms[0] = r_p3;
    assign w_mr[0] = '0;

    for (genvar k = 0; k < 16; k++) begin : g_mod
        ltcs_mod_cell #(
            .BIT (15 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_side  (w_ms[k]),
            .i_r     (w_mr[k]),
            .i_align (w_align),
            .o_side  (w_ms[k+1]),
            .o_r     (w_mr[k+1])
        );
    end

    // Output register.
    logic        r_out_vld;
    logic [15:0] r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= w_ms[16].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= w_ms[16].eq ? w_ms[16].bnd : (w_ms[16].bnd - w_mr[16][15:0]);
    end

    assign o_valid      = r_out_vld;
    assign o_chunk_size = r_out;
endmodule

// ===== hw/rtl/ltcs_checker.sv =====
// Port-level checks of the chunk sizing block, bound to its top level.
// Depends on latency_target_chunk_size_defines.svh.
`include "latency_target_chunk_size_defines.svh"

module ltcs_checker #(
    parameter int unsigned FRAC_BITS = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input logic psel,
    input logic penable,
    input logic pready
);
    localparam int unsigned LAT = FRAC_BITS + 39;

    // Every accepted item gives its result after the fixed latency.
    `LTCS_ASSERT_RST(a_latency, i_clk, i_rst_n, start && !busy, ##LAT o_valid)
    // The block never refuses an item.
    `LTCS_ASSERT_RST(a_no_busy, i_clk, i_rst_n, 1'b1, !busy)
    // Reset empties the pipeline.
    `LTCS_ASSERT_ALL(a_reset_flush, i_clk, !i_rst_n, !o_valid)
    // Register accesses complete without wait states.
    `LTCS_ASSERT_RST(a_pready, i_clk, i_rst_n, psel && penable, pready)
endmodule

bind latency_target_chunk_size ltcs_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_ltcs_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .psel    (psel),
    .penable (penable),
    .pready  (pready)
);
